// ===== hw/rtl/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
// Used by ffha_ctrl and the top level; no dependencies.
package ffha_pkg;

  localparam int HEAP_GRANULES = 4096;
  localparam int GRAN_SHIFT    = 3;   // 8-byte granules
  localparam int ADDR_W        = 12;  // header store index
  localparam int IDX_W         = 13;  // list index, LIST_END included
  localparam logic [IDX_W-1:0] LIST_END = IDX_W'(HEAP_GRANULES);
  localparam logic [IDX_W-1:0] STEP_MAX = IDX_W'(HEAP_GRANULES);

  typedef struct packed {
    logic [IDX_W-1:0] size;
    logic             used;
    logic [IDX_W-1:0] next;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_START,
    ST_A_LOOP,
    ST_A_EVAL,
    ST_A_WR_NB,
    ST_A_WR_CUR,
    ST_A_WR_PREV,
    ST_F_START,
    ST_F_CHK,
    ST_F_WALK,
    ST_F_WALK_EV,
    ST_F_LINK,
    ST_F_FWD,
    ST_F_BACK,
    ST_F_WR_H,
    ST_F_WR_PREV,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/ffha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// Allocator sequencer: clearing pass, first-fit search, split, free with merge.
// Uses ffha_pkg; drives the header store held in ffha_ram.
module ffha_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ffha_pkg::IDX_W-1:0]   heap_granules,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic                         s_action,
  input  logic [15:0]                  s_size,
  input  logic [11:0]                  s_ptr,
  output logic                         m_valid,
  input  logic                         m_ready,
  output logic [11:0]                  m_ptr,
  output logic                         m_ok,
  output logic                         ram_we,
  output logic [ffha_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [ffha_pkg::HDR_W-1:0]   ram_wdata,
  output logic [ffha_pkg::ADDR_W-1:0]  ram_raddr,
  input  logic [ffha_pkg::HDR_W-1:0]   ram_rdata
);

  ffha_pkg::state_t state, state_next;

  logic [15:0]                 bytes;
  logic [11:0]                 ptr;
  logic [ffha_pkg::IDX_W-1:0]  cur, cur_next;
  logic [ffha_pkg::ADDR_W-1:0] prev, prev_next;
  logic                        prev_valid, prev_valid_next;
  ffha_pkg::hdr_t              prevd, prevd_next;
  logic [ffha_pkg::IDX_W-1:0]  steps, steps_next;
  logic [ffha_pkg::IDX_W-1:0]  hsize, hsize_next;
  logic [ffha_pkg::IDX_W-1:0]  hnext, hnext_next;
  logic [ffha_pkg::IDX_W-1:0]  rem, rem_next;
  logic [ffha_pkg::IDX_W-1:0]  after, after_next;
  logic [ffha_pkg::IDX_W-1:0]  cursz, cursz_next;
  logic                        split, split_next;
  logic [ffha_pkg::IDX_W-1:0]  head, head_next;
  logic                        init, init_next;
  logic [11:0]                 res_ptr, res_ptr_next;
  logic                        res_ok, res_ok_next;
  logic [ffha_pkg::ADDR_W-1:0] clr_addr, clr_addr_next;
  logic                        m_valid_next;

  logic [ffha_pkg::IDX_W-1:0]  hlen;
  logic [16:0]                 bytes_up;
  logic [13:0]                 need;
  logic [11:0]                 h;
  logic [13:0]                 h_end_rd;
  logic [13:0]                 h_end;
  logic [13:0]                 prev_tail;
  logic [14:0]                 nb_pos;
  logic [ffha_pkg::IDX_W-1:0]  repl;
  ffha_pkg::hdr_t              rd;

  assign hlen     = (heap_granules > ffha_pkg::LIST_END) ? ffha_pkg::LIST_END : heap_granules;
  assign bytes_up = {1'b0, bytes} + 17'd7;
  assign need     = 14'(bytes_up >> ffha_pkg::GRAN_SHIFT) + 14'd1;
  assign h        = ptr - 12'd1;
  assign rd       = ffha_pkg::hdr_t'(ram_rdata);
  assign h_end_rd = {2'b00, h} + {1'b0, rd.size};
  assign h_end    = {2'b00, h} + {1'b0, hsize};
  assign prev_tail = {2'b00, prev} + {1'b0, prevd.size};
  assign nb_pos   = {2'b00, cur} + {1'b0, need};
  // link that replaces the allocated block in the free list
  assign repl     = split ? nb_pos[ffha_pkg::IDX_W-1:0] : after;
  assign s_ready  = (state == ffha_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffha_pkg::ST_CLEAR;
      clr_addr <= '0;
      head     <= ffha_pkg::LIST_END;
      init     <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      head     <= head_next;
      init     <= init_next;
      m_valid  <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      bytes <= s_size;
      ptr   <= s_ptr;
    end
    if (state == ffha_pkg::ST_DONE && (!m_valid || m_ready)) begin
      m_ptr <= res_ptr;
      m_ok  <= res_ok;
    end
    cur        <= cur_next;
    prev       <= prev_next;
    prev_valid <= prev_valid_next;
    prevd      <= prevd_next;
    steps      <= steps_next;
    hsize      <= hsize_next;
    hnext      <= hnext_next;
    rem        <= rem_next;
    after      <= after_next;
    cursz      <= cursz_next;
    split      <= split_next;
    res_ptr    <= res_ptr_next;
    res_ok     <= res_ok_next;
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    head_next       = head;
    init_next       = init;
    m_valid_next    = m_valid;
    cur_next        = cur;
    prev_next       = prev;
    prev_valid_next = prev_valid;
    prevd_next      = prevd;
    steps_next      = steps;
    hsize_next      = hsize;
    hnext_next      = hnext;
    rem_next        = rem;
    after_next      = after;
    cursz_next      = cursz;
    split_next      = split;
    res_ptr_next    = res_ptr;
    res_ok_next     = res_ok;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_raddr       = cur[ffha_pkg::ADDR_W-1:0];

    if (m_valid && m_ready) begin
      m_valid_next = 1'b0;
    end

    unique case (state)
      ffha_pkg::ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == '1) begin
          state_next = ffha_pkg::ST_IDLE;
        end
      end
      ffha_pkg::ST_IDLE: begin
        if (s_valid) begin
          state_next = (ffha_pkg::action_t'(s_action) == ffha_pkg::ACT_FREE)
                       ? ffha_pkg::ST_F_START : ffha_pkg::ST_A_START;
        end
      end
      ffha_pkg::ST_A_START: begin
        res_ptr_next    = '0;
        res_ok_next     = 1'b0;
        prev_valid_next = 1'b0;
        steps_next      = '0;
        cur_next        = head;
        if (bytes == '0) begin
          state_next = ffha_pkg::ST_DONE;
        end else begin
          state_next = ffha_pkg::ST_A_LOOP;
          if (!init) begin
            // lazy set-up: one free block spanning the heap
            init_next = 1'b1;
            if (hlen == '0) begin
              head_next = ffha_pkg::LIST_END;
              cur_next  = ffha_pkg::LIST_END;
            end else begin
              head_next = '0;
              cur_next  = '0;
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = ffha_pkg::HDR_W'({hlen, 1'b0, ffha_pkg::LIST_END});
            end
          end
        end
      end
      ffha_pkg::ST_A_LOOP: begin
        if (cur < ffha_pkg::LIST_END && steps <= ffha_pkg::STEP_MAX) begin
          state_next = ffha_pkg::ST_A_EVAL;
        end else begin
          state_next = ffha_pkg::ST_DONE;
        end
      end
      ffha_pkg::ST_A_EVAL: begin
        if ({1'b0, rd.size} >= need) begin
          rem_next   = rd.size - need[ffha_pkg::IDX_W-1:0];
          after_next = rd.next;
          split_next = (rd.size - need[ffha_pkg::IDX_W-1:0] >= 13'd2)
                       && (nb_pos < 15'(ffha_pkg::HEAP_GRANULES));
          cursz_next = split_next ? need[ffha_pkg::IDX_W-1:0] : rd.size;
          state_next = split_next ? ffha_pkg::ST_A_WR_NB : ffha_pkg::ST_A_WR_CUR;
        end else begin
          prev_next       = cur[ffha_pkg::ADDR_W-1:0];
          prevd_next      = rd;
          prev_valid_next = 1'b1;
          cur_next        = rd.next;
          steps_next      = steps + 1'b1;
          state_next      = ffha_pkg::ST_A_LOOP;
        end
      end
      ffha_pkg::ST_A_WR_NB: begin
        ram_we     = 1'b1;
        ram_waddr  = nb_pos[ffha_pkg::ADDR_W-1:0];
        ram_wdata  = ffha_pkg::HDR_W'({rem, 1'b0, after});
        state_next = ffha_pkg::ST_A_WR_CUR;
      end
      ffha_pkg::ST_A_WR_CUR: begin
        // cur keeps its old successor
        ram_we     = 1'b1;
        ram_waddr  = cur[ffha_pkg::ADDR_W-1:0];
        ram_wdata  = ffha_pkg::HDR_W'({cursz, 1'b1, after});
        state_next = ffha_pkg::ST_A_WR_PREV;
      end
      ffha_pkg::ST_A_WR_PREV: begin
        if (prev_valid) begin
          ram_we    = 1'b1;
          ram_waddr = prev;
          ram_wdata = ffha_pkg::HDR_W'({prevd.size, prevd.used, repl});
        end else begin
          head_next = repl;
        end
        res_ptr_next = cur[11:0] + 12'd1;
        res_ok_next  = 1'b1;
        state_next   = ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_F_START: begin
        res_ptr_next = '0;
        res_ok_next  = 1'b0;
        ram_raddr    = h;
        if (ptr == '0 || {1'b0, h} >= hlen || !init) begin
          state_next = ffha_pkg::ST_DONE;
        end else begin
          state_next = ffha_pkg::ST_F_CHK;
        end
      end
      ffha_pkg::ST_F_CHK: begin
        if (rd.size == '0 || h_end_rd > {1'b0, hlen} || !rd.used) begin
          state_next = ffha_pkg::ST_DONE;
        end else begin
          hsize_next      = rd.size;
          cur_next        = head;
          prev_valid_next = 1'b0;
          steps_next      = '0;
          state_next      = ffha_pkg::ST_F_WALK;
        end
      end
      ffha_pkg::ST_F_WALK: begin
        if (cur < ffha_pkg::LIST_END && cur < {1'b0, h} && steps <= ffha_pkg::STEP_MAX) begin
          state_next = ffha_pkg::ST_F_WALK_EV;
        end else begin
          if (cur > ffha_pkg::LIST_END) begin
            cur_next = ffha_pkg::LIST_END;
          end
          state_next = ffha_pkg::ST_F_LINK;
        end
      end
      ffha_pkg::ST_F_WALK_EV: begin
        prev_next       = cur[ffha_pkg::ADDR_W-1:0];
        prevd_next      = rd;
        prev_valid_next = 1'b1;
        cur_next        = rd.next;
        steps_next      = steps + 1'b1;
        state_next      = ffha_pkg::ST_F_WALK;
      end
      ffha_pkg::ST_F_LINK: begin
        hnext_next = cur;
        if (prev_valid) begin
          prevd_next.next = {1'b0, h};
        end else begin
          head_next = {1'b0, h};
        end
        if (cur < ffha_pkg::LIST_END && h_end == {1'b0, cur}) begin
          state_next = ffha_pkg::ST_F_FWD;
        end else begin
          state_next = ffha_pkg::ST_F_BACK;
        end
      end
      ffha_pkg::ST_F_FWD: begin
        hsize_next = hsize + rd.size;
        hnext_next = rd.next;
        state_next = ffha_pkg::ST_F_BACK;
      end
      ffha_pkg::ST_F_BACK: begin
        if (prev_valid && prev_tail == {2'b00, h}) begin
          prevd_next.size = prevd.size + hsize;
          prevd_next.next = hnext;
        end
        state_next = ffha_pkg::ST_F_WR_H;
      end
      ffha_pkg::ST_F_WR_H: begin
        ram_we     = 1'b1;
        ram_waddr  = h;
        ram_wdata  = ffha_pkg::HDR_W'({hsize, 1'b0, hnext});
        state_next = ffha_pkg::ST_F_WR_PREV;
      end
      ffha_pkg::ST_F_WR_PREV: begin
        if (prev_valid) begin
          ram_we    = 1'b1;
          ram_waddr = prev;
          ram_wdata = ffha_pkg::HDR_W'(prevd);
        end
        res_ok_next = 1'b1;
        state_next  = ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_DONE: begin
        if (!m_valid || m_ready) begin
          m_valid_next = 1'b1;
          state_next   = ffha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffha_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_ready |=> state != ffha_pkg::ST_IDLE)
    else $error("allocator still idle after a request transfer");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state != ffha_pkg::ST_IDLE)
    else $error("header store written while idle");
  a_ptr_implies_ok: assert property (@(posedge clk) disable iff (rst)
    m_valid && m_ptr != '0 |-> m_ok)
    else $error("non-null pointer returned without success");
`endif

endmodule

// ===== hw/rtl/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: APB register, sequencer, store.
// Depends on ffha_pkg, ffha_ctrl and ffha_ram.
//
// One request per transfer, one result per request. After reset a clearing
// pass zeroes the header store; no request is taken meanwhile. An allocate
// takes longer when the found block is split and for each free block visited
// before the first fit; a zero size skips the search. A free takes longer for
// each free block below it and when it merges with the block above; a rejected
// free ends before the walk. The next request can be taken in the same cycle
// as the result appears, and a result not yet taken holds the sequencer, once
// the next result is ready, until it is. The walk is bound by the one read per
// cycle of the header store and its registered read.
module first_fit_heap_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // size_bytes[15:0], ptr_granule[27:16], zero fill
  input  logic [0:0]  s_tuser,   // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // ptr_out[11:0], ok[12], zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ffha_pkg::IDX_W-1:0]  heap_granules;
  logic                        ram_we;
  logic [ffha_pkg::ADDR_W-1:0] ram_waddr;
  logic [ffha_pkg::HDR_W-1:0]  ram_wdata;
  logic [ffha_pkg::ADDR_W-1:0] ram_raddr;
  logic [ffha_pkg::HDR_W-1:0]  ram_rdata;
  logic [11:0]                 m_ptr;
  logic                        m_ok;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {19'd0, heap_granules} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_granules <= ffha_pkg::LIST_END;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      heap_granules <= pwdata[ffha_pkg::IDX_W-1:0];
    end
  end

  assign m_tdata = {3'd0, m_ok, m_ptr};

  ffha_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .heap_granules (heap_granules),
    .s_valid       (s_tvalid),
    .s_ready       (s_tready),
    .s_action      (s_tuser[0]),
    .s_size        (s_tdata[15:0]),
    .s_ptr         (s_tdata[27:16]),
    .m_valid       (m_tvalid),
    .m_ready       (m_tready),
    .m_ptr         (m_ptr),
    .m_ok          (m_ok),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  ffha_ram #(
    .WIDTH (ffha_pkg::HDR_W),
    .DEPTH (ffha_pkg::HEAP_GRANULES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== dv/first_fit_heap_allocator_top_tb.sv =====
// Self-checking bench for the first-fit heap allocator: streams allocate and free
// requests, predicts each result with a local heap model. Depends on ffha_pkg and first_fit_heap_allocator_top.
module first_fit_heap_allocator_top_tb;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  first_fit_heap_allocator_top dut (.*);

  initial forever #5 clk = ~clk;

  // local heap model
  int unsigned hp_len_reg;
  int unsigned hp_size [ffha_pkg::HEAP_GRANULES];
  bit          hp_used [ffha_pkg::HEAP_GRANULES];
  int unsigned hp_next [ffha_pkg::HEAP_GRANULES];
  int unsigned hp_head;
  bit          hp_init;

  typedef struct packed {
    logic [11:0] ptr;
    logic        ok;
  } alloc_res_t;

  alloc_res_t  res_q [$];
  int unsigned live_q [$];   // user pointers believed allocated
  int          mismatches = 0;
  int          stall_pct_s = 0, stall_pct_m = 0;
  int          idle_cnt = 0;
  bit          timed_out = 0;

  function automatic int unsigned cur_len();
    return hp_len_reg > ffha_pkg::HEAP_GRANULES ? ffha_pkg::HEAP_GRANULES : hp_len_reg;
  endfunction

  function automatic int unsigned heap_alloc(int unsigned bytes);
    int unsigned need, prv, cur, steps, sz, rem, aft, repl, nb, lim;
    lim = ffha_pkg::HEAP_GRANULES;
    prv = lim; steps = 0;
    if (bytes == 0) return 0;
    need = (bytes + 7) / 8 + 1;
    if (need < 2) need = 2;
    if (!hp_init) begin
      hp_init = 1;
      if (cur_len() == 0) hp_head = lim;
      else begin
        hp_head = 0; hp_size[0] = cur_len(); hp_used[0] = 0; hp_next[0] = lim;
      end
    end
    cur = hp_head;
    while (cur < lim && steps <= lim) begin
      sz = hp_size[cur];
      if (sz >= need) begin
        rem = sz - need; aft = hp_next[cur]; repl = aft;
        if (rem >= 2 && cur + need < lim) begin
          nb = cur + need;
          hp_size[nb] = rem; hp_used[nb] = 0; hp_next[nb] = aft;
          repl = nb; hp_size[cur] = need;
        end
        if (prv < lim) hp_next[prv] = repl; else hp_head = repl;
        hp_used[cur] = 1;
        return cur + 1;
      end
      prv = cur; cur = hp_next[cur]; steps++;
    end
    return 0;
  endfunction

  function automatic bit heap_release(int unsigned p);
    int unsigned h, bsz, prv, cur, steps, lim;
    lim = ffha_pkg::HEAP_GRANULES;
    prv = lim; steps = 0;
    if (p == 0) return 0;
    h = p - 1;
    if (h >= cur_len() || !hp_init) return 0;
    bsz = hp_size[h];
    if (bsz < 1 || h + bsz > cur_len() || !hp_used[h]) return 0;
    hp_used[h] = 0;
    cur = hp_head;
    while (cur < lim && cur < h && steps <= lim) begin
      prv = cur; cur = hp_next[cur]; steps++;
    end
    if (cur > lim) cur = lim;
    hp_next[h] = cur;
    if (prv < lim) hp_next[prv] = h; else hp_head = h;
    if (cur < lim && h + hp_size[h] == cur) begin
      hp_size[h] += hp_size[cur]; hp_next[h] = hp_next[cur];
    end
    if (prv < lim && prv + hp_size[prv] == h) begin
      hp_size[prv] += hp_size[h]; hp_next[prv] = hp_next[h];
    end
    return 1;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    alloc_res_t got, want;
    if (rst) m_tready <= 0;
    else begin
      if (m_tvalid && m_tready) begin
        got = '{ptr: m_tdata[11:0], ok: m_tdata[12]};
        if (res_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result ptr=%0d ok=%0d", got.ptr, got.ok);
        end else begin
          want = res_q.pop_front();
          if (got.ptr !== want.ptr || got.ok !== want.ok || m_tdata[15:13] !== 3'b0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp ptr=%0d ok=%0d, got ptr=%0d ok=%0d",
                       want.ptr, want.ok, got.ptr, got.ok);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct_m);
    end
  end

  // watchdog on cycles without any transfer; limit covers the clearing pass
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 200000 && !timed_out) begin
      timed_out = 1;
      $display("first_fit_heap_allocator_top_tb: done, errors");
      $finish;
    end
  end

  // valid stays up between back-to-back requests; gaps drop it
  task automatic send_req(bit act, int unsigned bytes, int unsigned ptr);
    alloc_res_t r;
    int unsigned got;
    while ($urandom_range(99) < stall_pct_s) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, ptr[11:0], bytes[15:0]};
    do @(posedge clk); while (!s_tready);
    if (act == ffha_pkg::ACT_ALLOC) begin
      got = heap_alloc(bytes);
      r = '{ptr: got[11:0], ok: got != 0};
      if (got != 0) live_q.push_back(got);
    end else begin
      r = '{ptr: 12'd0, ok: heap_release(ptr)};
    end
    res_q.push_back(r);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (res_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // register write only while idle; the model tracks it from the write edge on
  task automatic set_heap_len(int unsigned v);
    drain();
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    hp_len_reg = v & 13'h1fff;
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  function automatic int unsigned pick_live();
    int i;
    if (live_q.size() == 0) return $urandom_range(4095);
    i = $urandom_range(live_q.size() - 1);
    pick_live = live_q[i];
    live_q.delete(i);
  endfunction

  task automatic test_free_before_setup();
    send_req(ffha_pkg::ACT_FREE, 0, 1);
    send_req(ffha_pkg::ACT_FREE, 16'hffff, 12'hfff);
    send_req(ffha_pkg::ACT_FREE, 0, 0);
  endtask

  task automatic test_directed_alloc();
    int unsigned p1, p2, p3;
    send_req(ffha_pkg::ACT_ALLOC, 0, 0);
    send_req(ffha_pkg::ACT_ALLOC, 16'hffff, 0);    // too large
    send_req(ffha_pkg::ACT_ALLOC, 1, 0);
    send_req(ffha_pkg::ACT_ALLOC, 8, 12'hfff);
    send_req(ffha_pkg::ACT_ALLOC, 9, 0);
    send_req(ffha_pkg::ACT_ALLOC, 100, 0);
    p3 = pick_live(); p2 = pick_live(); p1 = pick_live();
    send_req(ffha_pkg::ACT_FREE, 0, p2);
    send_req(ffha_pkg::ACT_FREE, 0, p2);           // already free
    send_req(ffha_pkg::ACT_FREE, 0, p1);
    send_req(ffha_pkg::ACT_FREE, 0, p3);
    send_req(ffha_pkg::ACT_FREE, 0, 12'hfff);      // bad header
    send_req(ffha_pkg::ACT_FREE, 0, 0);            // null
    send_req(ffha_pkg::ACT_ALLOC, 32760, 0);       // exactly the heap
    send_req(ffha_pkg::ACT_FREE, 0, pick_live());
  endtask

  task automatic test_random(int n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45)
        send_req(ffha_pkg::ACT_ALLOC, $urandom_range(k < 5 ? 65535 : 600),
                 $urandom_range(4095));
      else if (k < 88) send_req(ffha_pkg::ACT_FREE, $urandom, pick_live());
      else send_req(ffha_pkg::ACT_FREE, $urandom, $urandom_range(4095));
    end
  endtask

  initial begin
    hp_len_reg = ffha_pkg::HEAP_GRANULES; hp_head = ffha_pkg::HEAP_GRANULES; hp_init = 0;
    foreach (hp_size[i]) begin hp_size[i] = 0; hp_used[i] = 0; hp_next[i] = 0; end
    repeat (3) @(posedge clk);
    rst <= 0;
    test_free_before_setup();
    test_directed_alloc();
    stall_pct_s = 85; test_random(110);
    stall_pct_s = 0; stall_pct_m = 85; test_random(110);
    // length shrunk after set-up: free list kept, bounds use new length
    set_heap_len(100);
    stall_pct_s = 7; stall_pct_m = 7; test_random(110);
    set_heap_len(8191);
    stall_pct_s = 0; stall_pct_m = 0; test_random(110);
    drain();
    if (mismatches == 0 && res_q.size() == 0)
      $display("first_fit_heap_allocator_top_tb: done, clean");
    else
      $display("first_fit_heap_allocator_top_tb: done, errors");
    $finish;
  end
endmodule
